// ===== rtl/core/dda_pkg.sv =====
// Package for the DDA line rasterizer: widths, codes, payload structs and
// the sequencer state type. Used by every module in rtl/core.
package dda_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 16;
  localparam int COLOR_BITS    = 32;
  localparam int DIVIDEND_BITS = COORD_BITS + FRAC_BITS;
  localparam int QUOT_BITS     = FRAC_BITS + 1;
  localparam int INC_BITS      = FRAC_BITS + 2;
  localparam int POS_BITS      = COORD_BITS + FRAC_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [COORD_BITS-1:0] CLIP_X_RESET = COORD_BITS'(1920);
  localparam logic [COORD_BITS-1:0] CLIP_Y_RESET = COORD_BITS'(1080);
  localparam logic [COLOR_BITS-1:0] COLOR_RESET  = 32'h0FFF_FFFF;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } dda_state_e;

  typedef struct packed {
    logic                  opcode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } dda_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  pixel_valid;
    logic                  line_done;
  } dda_out_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] mag;
    logic [COORD_BITS-1:0] divisor;
  } dda_div_req_t;

endpackage

// ===== rtl/core/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: sequencer, position state, clip
// logic and output register. Depends on dda_pkg and dda_div.
//
//   Channel   Direction  Signals                          Moves
//   in        input      in_valid_i/in_ready_o, in_data_i   load or step command
//   out       output     out_valid_o/out_ready_i, out_data_o  one pixel result
//   cfg       input      cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i  register write
//
// Steps stream at one per cycle while the output is taken. A load of a non-zero
// line holds the input while the x and then the y increment are computed, each
// started and then iterated on one shared restoring divider.
// A zero-length load starts no division. Reset is asynchronous and active low.
// A stalled output holds its result and blocks further input transfers.
module dda_line_rasterizer import dda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  dda_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output dda_out_t                out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COLOR_BITS-1:0]   cfg_data_i
);

  dda_state_e            state_q, state_d;
  logic                  active_q, active_d;
  logic [COORD_BITS-1:0] total_q, total_d;
  logic [COORD_BITS-1:0] count_q, count_d;
  logic [POS_BITS-1:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [INC_BITS-1:0]   inc_x_q, inc_x_d, inc_y_q, inc_y_d;
  logic                  neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [COORD_BITS-1:0] mag_y_q, mag_y_d;
  logic [COORD_BITS-1:0] clip_x_q, clip_y_q;
  logic [COLOR_BITS-1:0] color_q;
  logic                  out_valid_q, out_valid_d;
  dda_out_t              out_data_q, out_data_d;

  logic                  in_fire;
  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] ax, ay, new_total;
  logic                  clipped;
  logic [INC_BITS-1:0]   quot_ext, inc_signed;
  dda_div_req_t          div_req;
  logic                  div_done;
  logic [QUOT_BITS-1:0]  div_quot;

  dda_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    dx = {1'b0, in_data_i.end_x} - {1'b0, in_data_i.start_x};
    dy = {1'b0, in_data_i.end_y} - {1'b0, in_data_i.start_y};
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    new_total = (ax >= ay) ? ax : ay;
    clipped = (pos_x_q > {1'b0, clip_x_q, {FRAC_BITS{1'b0}}}) ||
              (pos_y_q > {1'b0, clip_y_q, {FRAC_BITS{1'b0}}});
    quot_ext = {1'b0, div_quot};
    inc_signed = ((state_q == ST_DIV_X) ? neg_x_q : neg_y_q) ? -quot_ext : quot_ext;

    state_d     = state_q;
    active_d    = active_q;
    total_d     = total_q;
    count_d     = count_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    inc_x_d     = inc_x_q;
    inc_y_d     = inc_y_q;
    neg_x_d     = neg_x_q;
    neg_y_d     = neg_y_q;
    mag_y_d     = mag_y_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    div_req     = '{start: 1'b0, mag: ax, divisor: new_total};

    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.opcode == OP_LOAD) begin
          total_d  = new_total;
          count_d  = '0;
          pos_x_d  = {1'b0, in_data_i.start_x, {FRAC_BITS{1'b0}}};
          pos_y_d  = {1'b0, in_data_i.start_y, {FRAC_BITS{1'b0}}};
          inc_x_d  = '0;
          inc_y_d  = '0;
          neg_x_d  = dx[COORD_BITS];
          neg_y_d  = dy[COORD_BITS];
          mag_y_d  = ay;
          active_d = 1'b0;
          if (new_total != '0) begin
            div_req.start = 1'b1;
            state_d       = ST_DIV_X;
          end
        end else if (in_fire) begin
          out_valid_d = 1'b1;
          out_data_d  = '{pixel_x: '0, pixel_y: '0, pixel_color: '0,
                          pixel_valid: 1'b0, line_done: 1'b1};
          if (active_q) begin
            if (clipped) begin
              active_d = 1'b0;
            end else begin
              count_d  = count_q + 1'b1;
              pos_x_d  = pos_x_q + {{(POS_BITS-INC_BITS){inc_x_q[INC_BITS-1]}}, inc_x_q};
              pos_y_d  = pos_y_q + {{(POS_BITS-INC_BITS){inc_y_q[INC_BITS-1]}}, inc_y_q};
              active_d = count_d < total_q;
              out_data_d = '{pixel_x: pos_x_q[FRAC_BITS +: COORD_BITS],
                             pixel_y: pos_y_q[FRAC_BITS +: COORD_BITS],
                             pixel_color: color_q, pixel_valid: 1'b1,
                             line_done: !active_d};
            end
          end
        end
      end
      ST_DIV_X: begin
        div_req.mag     = mag_y_q;
        div_req.divisor = total_q;
        if (div_done) begin
          inc_x_d       = inc_signed;
          div_req.start = 1'b1;
          state_d       = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        div_req.mag     = mag_y_q;
        div_req.divisor = total_q;
        if (div_done) begin
          inc_y_d  = inc_signed;
          active_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      total_q     <= '0;
      count_q     <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      inc_x_q     <= '0;
      inc_y_q     <= '0;
      out_valid_q <= 1'b0;
      clip_x_q    <= CLIP_X_RESET;
      clip_y_q    <= CLIP_Y_RESET;
      color_q     <= COLOR_RESET;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      total_q     <= total_d;
      count_q     <= count_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      inc_x_q     <= inc_x_d;
      inc_y_q     <= inc_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CLIP_X: clip_x_q <= cfg_data_i[COORD_BITS-1:0];
          CFG_CLIP_Y: clip_y_q <= cfg_data_i[COORD_BITS-1:0];
          CFG_COLOR:  color_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_x_q    <= neg_x_d;
    neg_y_q    <= neg_y_d;
    mag_y_q    <= mag_y_d;
    out_data_q <= out_data_d;
  end

  a_load_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.opcode == OP_LOAD && new_total != '0 |=> state_q == ST_DIV_X)
    else $error("A non-empty line load did not start the x division.");

  a_count_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> count_q < total_q)
    else $error("An active line has reached its step total.");

  a_div_done_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q != ST_IDLE)
    else $error("The divider finished while the sequencer was idle.");

  a_no_pixel_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.pixel_valid |-> out_data_q.line_done)
    else $error("A result without a pixel does not mark the line as done.");

endmodule

// ===== rtl/core/dda_div.sv =====
// Restoring divider, one quotient bit per cycle, for the line increments.
// Depends on dda_pkg.
module dda_div import dda_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dda_div_req_t         req_i,
  output logic                 done_o,
  output logic [QUOT_BITS-1:0] quot_o
);

  localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(DIVIDEND_BITS - 1);

  logic                     busy_q;
  logic                     done_q;
  logic [DIV_CNT_BITS-1:0]  cnt_q;
  logic [COORD_BITS-1:0]    rem_q, rem_d;
  logic [DIVIDEND_BITS-1:0] num_q, num_d;
  logic [COORD_BITS-1:0]    div_q;
  logic [COORD_BITS:0]      trial;
  logic                     ge;

  always_comb begin
    trial = {rem_q, num_q[DIVIDEND_BITS-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? COORD_BITS'(trial - {1'b0, div_q}) : trial[COORD_BITS-1:0];
    num_d = {num_q[DIVIDEND_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      num_q <= {req_i.mag, {FRAC_BITS{1'b0}}};
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q[QUOT_BITS-1:0];

endmodule
